>>> design/imuof_pkg.sv
// ----------------------------------------------------------------------------
// imuof_pkg
// Shared widths, register indexes, operand codes and fixed-point helpers for
// the gradient-descent orientation filter.
// ----------------------------------------------------------------------------
package imuof_pkg;

    localparam int GYRO_W  = 24;
    localparam int ACC_W   = 16;
    localparam int QUAT_W  = 32;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 1;
    localparam int MAG_W   = 42;   // magnitudes of every vector that gets normalized
    localparam int RATE_W  = 42;   // quaternion rate before integration
    localparam int WIDE_W  = 64;   // products and accumulators
    localparam int MUL_W   = 33;   // shared multiplier operand width

    localparam logic [CFG_W-1:0] GAIN_RESET   = 24'd167772;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 24'd83886;
    localparam logic signed [QUAT_W-1:0] ONE_Q30 = 32'sh4000_0000;

    localparam logic [CIDX_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [CIDX_W-1:0] REG_PERIOD = 1'b1;

    // second multiplier operand sources
    typedef enum logic [3:0] {
        OPB_Q0 = 4'd0,
        OPB_Q1 = 4'd1,
        OPB_Q2 = 4'd2,
        OPB_Q3 = 4'd3,
        OPB_T  = 4'd4,
        OPB_F  = 4'd5,
        OPB_AX = 4'd6,
        OPB_AY = 4'd7,
        OPB_GX = 4'd8,
        OPB_GY = 4'd9,
        OPB_GZ = 4'd10
    } opb_t;

    // one multiply-accumulate term of a sum of products
    typedef struct packed {
        logic [1:0] asel;
        opb_t       bsel;
        logic       neg;
        logic [1:0] shl;
        logic       first;
        logic       last;
        logic [1:0] dst;
    } term_t;

    function automatic term_t mk_term(input logic [1:0] asel, input opb_t bsel,
                                      input logic neg, input logic [1:0] shl,
                                      input logic first, input logic last,
                                      input logic [1:0] dst);
        term_t t;
        t.asel  = asel;
        t.bsel  = bsel;
        t.neg   = neg;
        t.shl   = shl;
        t.first = first;
        t.last  = last;
        t.dst   = dst;
        return t;
    endfunction

    // gyro terms of the quaternion rate, three per component
    function automatic term_t rate_term(input logic [3:0] k);
        term_t t;
        case (k)
            4'd0:    t = mk_term(2'd1, OPB_GX, 1'b1, 2'd0, 1'b1, 1'b0, 2'd0);
            4'd1:    t = mk_term(2'd2, OPB_GY, 1'b1, 2'd0, 1'b0, 1'b0, 2'd0);
            4'd2:    t = mk_term(2'd3, OPB_GZ, 1'b1, 2'd0, 1'b0, 1'b1, 2'd0);
            4'd3:    t = mk_term(2'd0, OPB_GX, 1'b0, 2'd0, 1'b1, 1'b0, 2'd1);
            4'd4:    t = mk_term(2'd2, OPB_GZ, 1'b0, 2'd0, 1'b0, 1'b0, 2'd1);
            4'd5:    t = mk_term(2'd3, OPB_GY, 1'b1, 2'd0, 1'b0, 1'b1, 2'd1);
            4'd6:    t = mk_term(2'd0, OPB_GY, 1'b0, 2'd0, 1'b1, 1'b0, 2'd2);
            4'd7:    t = mk_term(2'd1, OPB_GZ, 1'b1, 2'd0, 1'b0, 1'b0, 2'd2);
            4'd8:    t = mk_term(2'd3, OPB_GX, 1'b0, 2'd0, 1'b0, 1'b1, 2'd2);
            4'd9:    t = mk_term(2'd0, OPB_GZ, 1'b0, 2'd0, 1'b1, 1'b0, 2'd3);
            4'd10:   t = mk_term(2'd1, OPB_GY, 1'b0, 2'd0, 1'b0, 1'b0, 2'd3);
            4'd11:   t = mk_term(2'd2, OPB_GX, 1'b1, 2'd0, 1'b0, 1'b1, 2'd3);
            default: t = mk_term(2'd0, OPB_Q0, 1'b0, 2'd0, 1'b0, 1'b0, 2'd0);
        endcase
        return t;
    endfunction

    // first four terms build t and u, the rest build the gradient
    function automatic term_t corr_term(input logic [3:0] k);
        term_t t;
        case (k)
            4'd0:    t = mk_term(2'd1, OPB_Q1, 1'b0, 2'd0, 1'b1, 1'b0, 2'd0);
            4'd1:    t = mk_term(2'd2, OPB_Q2, 1'b0, 2'd0, 1'b0, 1'b1, 2'd0);
            4'd2:    t = mk_term(2'd0, OPB_Q0, 1'b0, 2'd0, 1'b1, 1'b0, 2'd1);
            4'd3:    t = mk_term(2'd3, OPB_Q3, 1'b0, 2'd0, 1'b0, 1'b1, 2'd1);
            4'd4:    t = mk_term(2'd0, OPB_T,  1'b0, 2'd2, 1'b1, 1'b0, 2'd0);
            4'd5:    t = mk_term(2'd2, OPB_AX, 1'b0, 2'd1, 1'b0, 1'b0, 2'd0);
            4'd6:    t = mk_term(2'd1, OPB_AY, 1'b1, 2'd1, 1'b0, 1'b1, 2'd0);
            4'd7:    t = mk_term(2'd1, OPB_F,  1'b0, 2'd2, 1'b1, 1'b0, 2'd1);
            4'd8:    t = mk_term(2'd3, OPB_AX, 1'b1, 2'd1, 1'b0, 1'b0, 2'd1);
            4'd9:    t = mk_term(2'd0, OPB_AY, 1'b1, 2'd1, 1'b0, 1'b1, 2'd1);
            4'd10:   t = mk_term(2'd2, OPB_F,  1'b0, 2'd2, 1'b1, 1'b0, 2'd2);
            4'd11:   t = mk_term(2'd0, OPB_AX, 1'b0, 2'd1, 1'b0, 1'b0, 2'd2);
            4'd12:   t = mk_term(2'd3, OPB_AY, 1'b1, 2'd1, 1'b0, 1'b1, 2'd2);
            4'd13:   t = mk_term(2'd3, OPB_T,  1'b0, 2'd2, 1'b1, 1'b0, 2'd3);
            4'd14:   t = mk_term(2'd1, OPB_AX, 1'b1, 2'd1, 1'b0, 1'b0, 2'd3);
            default: t = mk_term(2'd2, OPB_AY, 1'b1, 2'd1, 1'b0, 1'b1, 2'd3);
        endcase
        return t;
    endfunction

    // divide by 2^n, round half away from zero
    function automatic logic signed [WIDE_W-1:0] rnd_sh(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned n);
        logic [WIDE_W-1:0] m;
        m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        m = (m + (WIDE_W'(1) << (n - 1))) >> n;
        return v[WIDE_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [QUAT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[QUAT_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] m;
        m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        return m[MAG_W-1:0];
    endfunction

endpackage

>>> design/imu_orientation_gradient_filter.sv
// ----------------------------------------------------------------------------
// imu_orientation_gradient_filter
// Gyro plus accelerometer orientation update with gradient-descent correction.
// ----------------------------------------------------------------------------
// flow: in_ready is high only in idle, so a new sample is not taken until the
//   last one has been passed to the output register; each vector normalization
//   (max search, shift, sum of squares, 32-step root, four divides) is run once
//   without correction or three times with it; one shared 33x33 multiplier
// reset: quaternion to 1,0,0,0, gain and period to defaults, no result pending
module imu_orientation_gradient_filter
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_en,
    input  logic [imuof_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [imuof_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [imuof_pkg::GYRO_W-1:0]    gyro_x,
    input  logic signed [imuof_pkg::GYRO_W-1:0]    gyro_y,
    input  logic signed [imuof_pkg::GYRO_W-1:0]    gyro_z,
    input  logic signed [imuof_pkg::ACC_W-1:0]     accel_x,
    input  logic signed [imuof_pkg::ACC_W-1:0]     accel_y,
    input  logic signed [imuof_pkg::ACC_W-1:0]     accel_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [imuof_pkg::QUAT_W-1:0]    quat_w,
    output logic signed [imuof_pkg::QUAT_W-1:0]    quat_x,
    output logic signed [imuof_pkg::QUAT_W-1:0]    quat_y,
    output logic signed [imuof_pkg::QUAT_W-1:0]    quat_z,
    output logic                                   correction_applied
);
    import imuof_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RATE   = 13'b0000000000010,
        ST_CORR   = 13'b0000000000100,
        ST_BETA   = 13'b0000000001000,
        ST_INTEG  = 13'b0000000010000,
        ST_UMAX   = 13'b0000000100000,
        ST_UNORM  = 13'b0000001000000,
        ST_USQ    = 13'b0000010000000,
        ST_USQRT  = 13'b0000100000000,
        ST_UDLOAD = 13'b0001000000000,
        ST_UDIV   = 13'b0010000000000,
        ST_URET   = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_ACC  = 2'd0,
        RET_GRAD = 2'd1,
        RET_QUAT = 2'd2
    } ret_t;

    localparam logic signed [RATE_W-1:0] RATE_HI = 42'sd274877906943;
    localparam logic signed [RATE_W-1:0] RATE_LO = -42'sd274877906944;

    // control
    state_t                     state_reg, state_next;
    logic [4:0]                 idx_reg, idx_next;
    logic [1:0]                 comp_reg, comp_next;
    ret_t                       ret_reg, ret_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [QUAT_W-1:0]   q_reg [4];
    logic signed [QUAT_W-1:0]   q_next [4];
    logic [CFG_W-1:0]           gain_reg, gain_next;
    logic [CFG_W-1:0]           period_reg, period_next;

    // datapath
    logic signed [GYRO_W-1:0]   g_reg [3];
    logic signed [GYRO_W-1:0]   g_next [3];
    logic                       corr_reg, corr_next;
    logic signed [RATE_W-1:0]   d_reg [4];
    logic signed [RATE_W-1:0]   d_next [4];
    logic signed [WIDE_W-1:0]   acc_reg, acc_next;
    logic signed [QUAT_W-1:0]   t_reg, t_next;
    logic signed [QUAT_W-1:0]   f_reg, f_next;
    logic [MAG_W-1:0]           mag_reg [4];
    logic [MAG_W-1:0]           mag_next [4];
    logic                       sign_reg [4];
    logic                       sign_next [4];
    logic [MAG_W-1:0]           mx_reg, mx_next;
    logic                       zero_reg, zero_next;
    logic [WIDE_W-1:0]          sq_rem_reg, sq_rem_next;
    logic [WIDE_W-1:0]          sq_res_reg, sq_res_next;
    logic [WIDE_W-1:0]          sq_bit_reg, sq_bit_next;
    logic [QUAT_W-1:0]          m_reg, m_next;
    logic [QUAT_W:0]            rem_reg, rem_next;
    logic [QUAT_W-1:0]          num_reg, num_next;
    logic [QUAT_W-1:0]          quo_reg, quo_next;
    logic signed [QUAT_W-1:0]   un_reg [4];
    logic signed [QUAT_W-1:0]   un_next [4];
    logic signed [WIDE_W-1:0]   prod_reg;
    logic signed [QUAT_W-1:0]   qo_reg [4];
    logic signed [QUAT_W-1:0]   qo_next [4];
    logic                       co_reg, co_next;

    // shared multiplier
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_full;

    // combinational temporaries
    term_t                      iss, con;
    logic [4:0]                 idx_m1;
    logic signed [WIDE_W-1:0]   w_val, w_term, w_r, w_p, w_f;
    logic signed [QUAT_W-1:0]   w_u;
    logic signed [RATE_W-1:0]   w_sat;
    logic [MAG_W-1:0]           w_mx;
    logic [WIDE_W-1:0]          w_tst;
    logic [QUAT_W:0]            w_rem2;
    logic                       w_qb;
    logic [QUAT_W-1:0]          w_quo;
    logic [2*QUAT_W-5:0]        w_num;
    logic [1:0]                 w_sel;

    assign in_ready           = (state_reg == ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign quat_w             = qo_reg[0];
    assign quat_x             = qo_reg[1];
    assign quat_y             = qo_reg[2];
    assign quat_z             = qo_reg[3];
    assign correction_applied = co_reg;

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[WIDE_W-1:0];
    end

    // operand select for the multiplier
    always_comb
    begin
        idx_m1 = idx_reg - 5'd1;
        iss    = (state_reg == ST_CORR) ? corr_term(idx_reg[3:0]) : rate_term(idx_reg[3:0]);
        con    = (state_reg == ST_CORR) ? corr_term(idx_m1[3:0]) : rate_term(idx_m1[3:0]);
        w_sat  = d_reg[idx_reg[2:1]];
        if (w_sat > RATE_HI)
            w_sat = RATE_HI;
        else if (w_sat < RATE_LO)
            w_sat = RATE_LO;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RATE, ST_CORR:
            begin
                mul_a = MUL_W'(q_reg[iss.asel]);
                case (iss.bsel)
                    OPB_Q0:  mul_b = MUL_W'(q_reg[0]);
                    OPB_Q1:  mul_b = MUL_W'(q_reg[1]);
                    OPB_Q2:  mul_b = MUL_W'(q_reg[2]);
                    OPB_Q3:  mul_b = MUL_W'(q_reg[3]);
                    OPB_T:   mul_b = MUL_W'(t_reg);
                    OPB_F:   mul_b = MUL_W'(f_reg);
                    OPB_AX:  mul_b = MUL_W'(un_reg[0]);
                    OPB_AY:  mul_b = MUL_W'(un_reg[1]);
                    OPB_GX:  mul_b = MUL_W'(g_reg[0]);
                    OPB_GY:  mul_b = MUL_W'(g_reg[1]);
                    OPB_GZ:  mul_b = MUL_W'(g_reg[2]);
                    default: mul_b = '0;
                endcase
            end
            ST_BETA:
            begin
                mul_a = MUL_W'(un_reg[idx_reg[1:0]]);
                mul_b = $signed({{(MUL_W-CFG_W){1'b0}}, gain_reg});
            end
            ST_INTEG:
            begin
                // rate split in a signed high part and an unsigned low 16 bits
                if (idx_reg[0])
                    mul_a = $signed({{(MUL_W-16){1'b0}}, w_sat[15:0]});
                else
                    mul_a = $signed({{(MUL_W-RATE_W+19){w_sat[RATE_W-1]}},
                                     w_sat[RATE_W-4:16]});
                mul_b = $signed({{(MUL_W-CFG_W){1'b0}}, period_reg});
            end
            ST_USQ:
            begin
                mul_a = $signed({3'b000, mag_reg[idx_reg[1:0]][29:0]});
                mul_b = $signed({3'b000, mag_reg[idx_reg[1:0]][29:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        comp_next      = comp_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        gain_next      = gain_reg;
        period_next    = period_reg;
        corr_next      = corr_reg;
        acc_next       = acc_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        mx_next        = mx_reg;
        zero_next      = zero_reg;
        sq_rem_next    = sq_rem_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        m_next         = m_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        co_next        = co_reg;
        for (int i = 0; i < 3; i++)
            g_next[i] = g_reg[i];
        for (int i = 0; i < 4; i++)
        begin
            q_next[i]    = q_reg[i];
            d_next[i]    = d_reg[i];
            mag_next[i]  = mag_reg[i];
            sign_next[i] = sign_reg[i];
            un_next[i]   = un_reg[i];
            qo_next[i]   = qo_reg[i];
        end
        w_val  = '0;
        w_term = '0;
        w_r    = '0;
        w_p    = '0;
        w_f    = '0;
        w_u    = '0;
        w_mx   = '0;
        w_tst  = '0;
        w_rem2 = '0;
        w_qb   = 1'b0;
        w_quo  = '0;
        w_num  = '0;
        w_sel  = idx_m1[2:1];

        if (cfg_en)
        begin
            case (cfg_index)
                REG_GAIN:   gain_next   = cfg_data;
                REG_PERIOD: period_next = cfg_data;
                default:    gain_next   = gain_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    g_next[0]    = gyro_x;
                    g_next[1]    = gyro_y;
                    g_next[2]    = gyro_z;
                    mag_next[0]  = mag_of(WIDE_W'(accel_x));
                    mag_next[1]  = mag_of(WIDE_W'(accel_y));
                    mag_next[2]  = mag_of(WIDE_W'(accel_z));
                    mag_next[3]  = '0;
                    sign_next[0] = accel_x[ACC_W-1];
                    sign_next[1] = accel_y[ACC_W-1];
                    sign_next[2] = accel_z[ACC_W-1];
                    sign_next[3] = 1'b0;
                    corr_next    = (accel_x != '0) || (accel_y != '0) || (accel_z != '0);
                    idx_next     = '0;
                    state_next   = ST_RATE;
                end
            end

            ST_RATE:
            begin
                if (idx_reg != 5'd0)
                begin
                    w_val = (con.first ? '0 : acc_reg) + (con.neg ? -prod_reg : prod_reg);
                    acc_next = w_val;
                    if (con.last)
                        d_next[con.dst] = RATE_W'(rnd_sh(w_val, 17));
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd12)
                begin
                    idx_next = '0;
                    if (corr_reg)
                    begin
                        mx_next    = '0;
                        ret_next   = RET_ACC;
                        state_next = ST_UMAX;
                    end
                    else
                        state_next = ST_INTEG;
                end
            end

            ST_CORR:
            begin
                if (idx_reg != 5'd0)
                begin
                    w_r    = rnd_sh(prod_reg, 30);
                    w_term = w_r <<< con.shl;
                    if (con.neg)
                        w_term = -w_term;
                    w_val    = (con.first ? '0 : acc_reg) + w_term;
                    acc_next = w_val;
                    if (con.last)
                    begin
                        if (idx_m1 < 5'd4)
                        begin
                            if (con.dst == 2'd0)
                                t_next = sat32(w_val);
                            else
                            begin
                                // u is only needed to form f
                                w_u    = sat32(w_val);
                                w_f    = WIDE_W'(w_u) + (WIDE_W'(t_reg) <<< 1)
                                         + WIDE_W'(un_reg[2]) - WIDE_W'(ONE_Q30);
                                f_next = sat32(w_f);
                            end
                        end
                        else
                        begin
                            mag_next[con.dst]  = mag_of(w_val);
                            sign_next[con.dst] = w_val[WIDE_W-1];
                        end
                    end
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd16)
                begin
                    idx_next   = '0;
                    mx_next    = '0;
                    ret_next   = RET_GRAD;
                    state_next = ST_UMAX;
                end
            end

            ST_BETA:
            begin
                if (idx_reg != 5'd0)
                    d_next[idx_m1[1:0]] = RATE_W'(WIDE_W'(d_reg[idx_m1[1:0]])
                                                  - rnd_sh(prod_reg, 24));
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd4)
                begin
                    idx_next   = '0;
                    state_next = ST_INTEG;
                end
            end

            ST_INTEG:
            begin
                if (idx_reg != 5'd0)
                begin
                    if (!idx_m1[0])
                        acc_next = prod_reg <<< 16;
                    else
                    begin
                        w_val = acc_reg + prod_reg;
                        w_p   = WIDE_W'(q_reg[w_sel]) + rnd_sh(w_val, 24);
                        mag_next[w_sel]  = mag_of(w_p);
                        sign_next[w_sel] = w_p[WIDE_W-1];
                    end
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd8)
                begin
                    idx_next   = '0;
                    mx_next    = '0;
                    ret_next   = RET_QUAT;
                    state_next = ST_UMAX;
                end
            end

            ST_UMAX:
            begin
                w_mx     = (mag_reg[idx_reg[1:0]] > mx_reg) ? mag_reg[idx_reg[1:0]] : mx_reg;
                mx_next  = w_mx;
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd3)
                begin
                    idx_next = '0;
                    if (w_mx == '0)
                    begin
                        zero_next = 1'b1;
                        for (int i = 0; i < 4; i++)
                            un_next[i] = '0;
                        state_next = ST_URET;
                    end
                    else
                        state_next = ST_UNORM;
                end
            end

            ST_UNORM:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (mx_reg[MAG_W-1:30] != '0)
                begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 4; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (!mx_reg[29])
                begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 4; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    idx_next    = '0;
                    sq_rem_next = '0;
                    state_next  = ST_USQ;
                end
            end

            ST_USQ:
            begin
                if (idx_reg != 5'd0)
                    sq_rem_next = sq_rem_reg + WIDE_W'(prod_reg);
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd4)
                begin
                    idx_next    = '0;
                    sq_res_next = '0;
                    sq_bit_next = WIDE_W'(1) << 62;
                    state_next  = ST_USQRT;
                end
            end

            ST_USQRT:
            begin
                w_tst = sq_res_reg + sq_bit_reg;
                if (sq_rem_reg >= w_tst)
                begin
                    sq_rem_next = sq_rem_reg - w_tst;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                idx_next    = idx_reg + 5'd1;
                if (idx_reg == 5'd31)
                begin
                    m_next     = sq_res_next[QUAT_W-1:0];
                    comp_next  = '0;
                    state_next = ST_UDLOAD;
                end
            end

            ST_UDLOAD:
            begin
                // numerator is mag * 2^30 + floor(m / 2)
                w_num      = {mag_reg[comp_reg][29:0], m_reg[30:1]};
                rem_next   = {5'b00000, w_num[2*QUAT_W-5:QUAT_W]};
                num_next   = w_num[QUAT_W-1:0];
                quo_next   = '0;
                idx_next   = '0;
                state_next = ST_UDIV;
            end

            ST_UDIV:
            begin
                w_rem2 = {rem_reg[QUAT_W-1:0], num_reg[QUAT_W-1]};
                w_qb   = (w_rem2 >= {1'b0, m_reg});
                rem_next = w_qb ? (w_rem2 - {1'b0, m_reg}) : w_rem2;
                num_next = num_reg << 1;
                w_quo    = {quo_reg[QUAT_W-2:0], w_qb};
                quo_next = w_quo;
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd31)
                begin
                    un_next[comp_reg] = sign_reg[comp_reg] ? -$signed(w_quo) : $signed(w_quo);
                    if (comp_reg == 2'd3)
                    begin
                        zero_next  = 1'b0;
                        state_next = ST_URET;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_UDLOAD;
                    end
                end
            end

            ST_URET:
            begin
                idx_next = '0;
                case (ret_reg)
                    RET_ACC:  state_next = ST_CORR;
                    RET_GRAD: state_next = ST_BETA;
                    RET_QUAT:
                    begin
                        for (int i = 0; i < 4; i++)
                            q_next[i] = zero_reg ? '0 : un_reg[i];
                        if (zero_reg)
                            q_next[0] = ONE_Q30;
                        state_next = ST_DONE;
                    end
                    default:  state_next = ST_DONE;
                endcase
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    for (int i = 0; i < 4; i++)
                        qo_next[i] = q_reg[i];
                    co_next        = corr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            comp_reg      <= '0;
            ret_reg       <= RET_ACC;
            out_valid_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
            period_reg    <= PERIOD_RESET;
            q_reg[0]      <= ONE_Q30;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            comp_reg      <= comp_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            period_reg    <= period_next;
            for (int i = 0; i < 4; i++)
                q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        corr_reg   <= corr_next;
        acc_reg    <= acc_next;
        t_reg      <= t_next;
        f_reg      <= f_next;
        mx_reg     <= mx_next;
        zero_reg   <= zero_next;
        sq_rem_reg <= sq_rem_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        m_reg      <= m_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        co_reg     <= co_next;
        for (int i = 0; i < 3; i++)
            g_reg[i] <= g_next[i];
        for (int i = 0; i < 4; i++)
        begin
            d_reg[i]    <= d_next[i];
            mag_reg[i]  <= mag_next[i];
            sign_reg[i] <= sign_next[i];
            un_reg[i]   <= un_next[i];
            qo_reg[i]   <= qo_next[i];
        end
    end

endmodule

>>> tb/imu_orientation_gradient_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_orientation_gradient_filter_test
// Drives gyro and accelerometer samples through the orientation filter under
// several gain and sample period settings, with random gaps on both sides.
// An in-bench fixed-point model of the update predicts every quaternion.
// ----------------------------------------------------------------------------
module imu_orientation_gradient_filter_test;
    import imuof_pkg::*;

    typedef longint vec4_t [4];

    typedef struct {
        logic signed [QUAT_W-1:0] q [4];
        logic                     corr;
    } attitude_t;

    typedef struct {
        logic signed [GYRO_W-1:0] g [3];
        logic signed [ACC_W-1:0]  a [3];
        bit                       typed;
        attitude_t                res;
    } sample_row_t;

    localparam longint ONE = 64'sd1 << 30;
    localparam longint RATE_MAX = 64'sd1 << 38;
    localparam int CYCLE_LIMIT = 6000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_en = 1'b0;
    logic [CIDX_W-1:0] cfg_index = REG_GAIN;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [GYRO_W-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic signed [ACC_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
    logic correction_applied;

    imu_orientation_gradient_filter DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state
    longint att_q [4];
    longint gain_q24;
    longint period_q24;

    attitude_t pending_att [$];
    int mismatches = 0;
    int cycles = 0;
    bit no_idle = 1'b0;

    function automatic longint div_round(longint v, int n);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (n - 1))) >> n;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, -(64'sd1 << 31), (64'sd1 << 31) - 1);
    endfunction

    function automatic longint mul30(longint a, longint b);
        return div_round(a * b, 30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector in Q.30 of the first n components; 0 when all are zero
    function automatic bit normalize(input vec4_t c, input int n, output vec4_t o);
        longint unsigned a [4];
        longint unsigned mx, s, m, r;
        int rs, ls;
        mx = 0;
        s = 0;
        rs = 0;
        ls = 0;
        o = '{0, 0, 0, 0};
        for (int i = 0; i < n; i++)
        begin
            a[i] = c[i] < 0 ? -c[i] : c[i];
            if (a[i] > mx)
                mx = a[i];
        end
        if (mx == 0)
            return 1'b0;
        while ((mx >> rs) >= (64'd1 << 30))
            rs++;
        if (rs == 0)
            while ((mx << ls) < (64'd1 << 29))
                ls++;
        for (int i = 0; i < n; i++)
        begin
            a[i] = (a[i] >> rs) << ls;
            s += a[i] * a[i];
        end
        m = int_sqrt(s);
        for (int i = 0; i < n; i++)
        begin
            r = ((a[i] << 30) + m / 2) / m;
            o[i] = c[i] < 0 ? -longint'(r) : longint'(r);
        end
        return 1'b1;
    endfunction

    function automatic attitude_t update_attitude(input logic signed [GYRO_W-1:0] g [3],
                                                  input logic signed [ACC_W-1:0] a [3]);
        longint gx, gy, gz, q0, q1, q2, q3, t, u, f, r;
        vec4_t acc, an, s, sn, d, p, nq;
        bit corr;
        attitude_t res;
        gx = g[0];
        gy = g[1];
        gz = g[2];
        q0 = att_q[0];
        q1 = att_q[1];
        q2 = att_q[2];
        q3 = att_q[3];
        acc = '{a[0], a[1], a[2], 0};
        d[0] = div_round(-q1 * gx - q2 * gy - q3 * gz, 17);
        d[1] = div_round(q0 * gx + q2 * gz - q3 * gy, 17);
        d[2] = div_round(q0 * gy - q1 * gz + q3 * gx, 17);
        d[3] = div_round(q0 * gz + q1 * gy - q2 * gx, 17);
        corr = normalize(acc, 3, an);
        if (corr)
        begin
            t = clamp32(mul30(q1, q1) + mul30(q2, q2));
            u = clamp32(mul30(q0, q0) + mul30(q3, q3));
            f = clamp32(u + 2 * t + an[2] - ONE);
            s[0] = 4 * mul30(q0, t) + 2 * (mul30(q2, an[0]) - mul30(q1, an[1]));
            s[1] = 4 * mul30(q1, f) - 2 * (mul30(q3, an[0]) + mul30(q0, an[1]));
            s[2] = 4 * mul30(q2, f) + 2 * (mul30(q0, an[0]) - mul30(q3, an[1]));
            s[3] = 4 * mul30(q3, t) - 2 * (mul30(q1, an[0]) + mul30(q2, an[1]));
            void'(normalize(s, 4, sn));
            for (int i = 0; i < 4; i++)
                d[i] -= div_round(gain_q24 * sn[i], 24);
        end
        for (int i = 0; i < 4; i++)
        begin
            r = clamp(d[i], -RATE_MAX, RATE_MAX - 1);
            p[i] = att_q[i] + div_round(r * period_q24, 24);
        end
        // a vanishing quaternion falls back to identity
        if (!normalize(p, 4, nq))
            nq = '{ONE, 0, 0, 0};
        for (int i = 0; i < 4; i++)
        begin
            att_q[i] = longint'($signed(nq[i][31:0]));
            res.q[i] = nq[i][31:0];
        end
        res.corr = corr;
        return res;
    endfunction

    function automatic bit same_attitude(input attitude_t x, input attitude_t y);
        bit same;
        same = (x.corr === y.corr);
        for (int i = 0; i < 4; i++)
            if (x.q[i] !== y.q[i])
                same = 1'b0;
        return same;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 200);
    endfunction

    // output side: random stall and result compare
    int stall_left = 0;
    always @(posedge clk)
    begin
        attitude_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_att.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h %h %h", quat_w, quat_x,
                                 quat_y, quat_z);
                end
                else
                begin
                    e = pending_att.pop_front();
                    if (e.q[0] !== quat_w || e.q[1] !== quat_x || e.q[2] !== quat_y ||
                        e.q[3] !== quat_z || e.corr !== correction_applied)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h %h %h %h %b act %h %h %h %h %b",
                                     e.q[0], e.q[1], e.q[2], e.q[3], e.corr,
                                     quat_w, quat_x, quat_y, quat_z, correction_applied);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left <= gap_len();
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input longint unsigned val);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_GAIN)
            gain_q24 = val & 64'hFF_FFFF;
        else
            period_q24 = val & 64'hFF_FFFF;
    endtask

    // one transfer on the input side; valid stays high into the next item
    task automatic send_sample(input logic signed [GYRO_W-1:0] g [3],
                               input logic signed [ACC_W-1:0] a [3],
                               output attitude_t res);
        in_valid <= 1'b1;
        gyro_x <= g[0];
        gyro_y <= g[1];
        gyro_z <= g[2];
        accel_x <= a[0];
        accel_y <= a[1];
        accel_z <= a[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = update_attitude(g, a);
        pending_att.push_back(res);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_att.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    sample_row_t directed [] = '{
        '{'{0, 0, 0}, '{0, 0, 0}, 1, '{'{32'sh4000_0000, 0, 0, 0}, 1'b0}},
        '{'{0, 0, 0}, '{0, 0, 1}, 1, '{'{32'sh4000_0000, 0, 0, 0}, 1'b1}},
        '{'{8388607, 8388607, 8388607}, '{0, 0, 0}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{-8388608, -8388608, -8388608}, '{0, 0, 0}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{65536, 0, 0}, '{32767, 32767, 32767}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{0, -65536, 0}, '{-32768, -32768, -32768}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{0, 0, 131072}, '{32767, 0, 0}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{1, -1, 1}, '{0, -32768, 0}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{-1, 1, -1}, '{0, 0, -32768}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{8388607, -8388608, 0}, '{1, -1, 1}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{0, 0, 0}, '{0, 0, -1}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{-300000, 200000, 5000}, '{100, -2000, 16000}, 0, '{'{0, 0, 0, 0}, 1'b0}},
        '{'{0, 0, 0}, '{0, 0, 0}, 0, '{'{0, 0, 0, 0}, 1'b0}}
    };

    initial
    begin
        attitude_t got;
        logic signed [GYRO_W-1:0] g [3];
        logic signed [ACC_W-1:0] a [3];
        int kind, gap;
        att_q = '{ONE, 0, 0, 0};
        gain_q24 = GAIN_RESET;
        period_q24 = PERIOD_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_sample(directed[i].g, directed[i].a, got);
            if (directed[i].typed && !same_attitude(got, directed[i].res))
            begin
                mismatches++;
                $display("directed row %0d disagrees with typed value", i);
            end
            gap = gap_len();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        drain();

        // settings: defaults, zero, max, then two random ones
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: ;
                1: begin write_reg(REG_GAIN, 0); write_reg(REG_PERIOD, 0); end
                2: begin write_reg(REG_GAIN, 24'hFF_FFFF); write_reg(REG_PERIOD, 24'hFF_FFFF); end
                default:
                begin
                    write_reg(REG_GAIN, $urandom_range(0, 24'h0F_FFFF));
                    write_reg(REG_PERIOD, $urandom_range(0, 24'h0F_FFFF));
                end
            endcase
            no_idle = (ph == 3);
            for (int n = 0; n < 250; n++)
            begin
                kind = $urandom_range(0, 9);
                for (int k = 0; k < 3; k++)
                begin
                    if (kind == 0)
                        g[k] = GYRO_W'($urandom);
                    else
                        g[k] = GYRO_W'($signed($urandom_range(0, 524287)) - 262144);
                    a[k] = ACC_W'($urandom);
                end
                if (kind == 1)
                    a = '{0, 0, 0};
                else if (kind == 2)
                begin
                    a = '{0, 0, 0};
                    a[$urandom_range(0, 2)] = ACC_W'($urandom);
                end
                send_sample(g, a, got);
                gap = gap_len();
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
